// ===== rtl/core/mfw_pkg.sv =====
// ----------------------------------------------------------------------------
// mfw_pkg
// Shared types and constants of the median filter window block.
// ----------------------------------------------------------------------------
package mfw_pkg;

    localparam int MAX_WINDOW  = 7;
    localparam int MAX_WIDTH   = 1024;
    localparam int PIXEL_BITS  = 16;
    localparam int MAX_HEIGHT  = 4096;
    localparam int STORE_ROWS  = MAX_WINDOW + 1;
    localparam int MAX_OFF     = (MAX_WINDOW - 1) / 2;
    localparam int MAX_TAPS    = MAX_WINDOW * MAX_WINDOW;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int SROW_BITS   = $clog2(STORE_ROWS);
    localparam int ADDR_BITS   = SROW_BITS + COL_BITS;
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int OFF_BITS    = $clog2(MAX_OFF + 1);
    localparam int TAP_BITS    = $clog2(MAX_TAPS + 1);
    localparam int LEAD_BITS   = ROW_BITS + COL_BITS + 1;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS_RD,
        ST_LOAD,
        ST_RANK,
        ST_OUT
    } mfw_state_t;

endpackage

// ===== rtl/core/mfw_ranker.sv =====
// ----------------------------------------------------------------------------
// mfw_ranker
// Streams window values in one per cycle and finds the one at the middle rank
// (count/2) with a shared compare unit: each candidate is counted against all taps.
// ----------------------------------------------------------------------------
module mfw_ranker
    import mfw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,       // value presented for the buffer
    input  logic [TAP_BITS-1:0]   load_idx,
    input  logic [PIXEL_BITS-1:0] load_val,
    input  logic                  start,      // begin ranking
    input  logic [TAP_BITS-1:0]   count,      // number of taps
    output logic                  done,
    output logic [PIXEL_BITS-1:0] result
);

    logic [PIXEL_BITS-1:0] buf_mem [MAX_TAPS];
    logic [TAP_BITS-1:0]   cand_reg, cand_next;
    logic [TAP_BITS-1:0]   scan_reg, scan_next;
    logic [TAP_BITS-1:0]   less_reg, less_next;
    logic [TAP_BITS-1:0]   leq_reg, leq_next;
    logic [PIXEL_BITS-1:0] cval_reg, sval_reg;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [PIXEL_BITS-1:0] result_reg, result_next;
    logic [TAP_BITS-1:0]   rank;
    logic [TAP_BITS-1:0]   rd_c, rd_s;
    logic                  lt, le;
    logic [TAP_BITS-1:0]   less_f, leq_f;

    assign rank = count >> 1;

    // Buffer write and registered reads of candidate and scanned value.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_mem[load_idx[$clog2(MAX_TAPS)-1:0]] <= load_val;
        end
        cval_reg <= buf_mem[rd_c[$clog2(MAX_TAPS)-1:0]];
        sval_reg <= buf_mem[rd_s[$clog2(MAX_TAPS)-1:0]];
    end

    // One compare per cycle; counts of smaller and smaller-or-equal values.
    assign lt     = sval_reg < cval_reg;
    assign le     = sval_reg <= cval_reg;
    assign less_f = less_reg + TAP_BITS'(lt);
    assign leq_f  = leq_reg + TAP_BITS'(le);

    always_comb
    begin
        cand_next   = cand_reg;
        scan_next   = scan_reg;
        less_next   = less_reg;
        leq_next    = leq_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        rd_c        = cand_reg;
        rd_s        = scan_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cand_next = '0;
            scan_next = '0;
            rd_c      = '0;
            rd_s      = '0;
            less_next = '0;
            leq_next  = '0;
        end
        else if (busy_reg)
        begin
            // scan_reg points one past the value now registered.
            if (scan_reg != '0)
            begin
                less_next = less_f;
                leq_next  = leq_f;
            end
            if (scan_reg == count)
            begin
                if (less_f <= rank && rank < leq_f)
                begin
                    result_next = cval_reg;
                    done_next   = 1'b1;
                    busy_next   = 1'b0;
                end
                cand_next = cand_reg + 1'b1;
                scan_next = '0;
                less_next = '0;
                leq_next  = '0;
                rd_c      = cand_reg + 1'b1;
                rd_s      = '0;
            end
            else
            begin
                scan_next = scan_reg + 1'b1;
                rd_s      = scan_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg   <= cand_next;
        scan_reg   <= scan_next;
        less_reg   <= less_next;
        leq_reg    <= leq_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/core/median_filter_window.sv =====
// ----------------------------------------------------------------------------
// median_filter_window
// Streaming 2-D square median filter over a row store of recent image rows.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and leave in raster order, lagging by
// off*width+off transfers (off = half the window). A pixel within off of an
// edge passes through; others get the median of their window. A transfer
// that produces a filtered pixel reads its n = (2*off+1)^2 taps from the row
// store one per cycle and ranks them in a shared compare unit that counts
// one candidate against all taps. Flush items (tuser = 1) after the frame
// push out the tail. The row store has no reset; every read hits an entry
// written in the same frame.
module median_filter_window
    import mfw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] pixel_in
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] pixel_out
    output logic        m_tlast,   // frame_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    logic [2:0]  win_reg;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic        cfg_we;
    logic [1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= 3'd3;
            width_reg  <= 11'd1024;
            height_reg <= 13'd1024;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_WINDOW: win_reg    <= pwdata[2:0];
                REG_WIDTH:  width_reg  <= pwdata[10:0];
                REG_HEIGHT: height_reg <= pwdata[12:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_WINDOW: prdata = {29'd0, win_reg};
            REG_WIDTH:  prdata = {21'd0, width_reg};
            REG_HEIGHT: prdata = {19'd0, height_reg};
            default:    prdata = '0;
        endcase
    end

    // Effective geometry.
    logic [10:0]         w_eff;
    logic [12:0]         h_eff;
    logic [OFF_BITS-1:0] off;
    logic [2:0]          side;
    logic [TAP_BITS-1:0] taps;
    logic [LEAD_BITS-1:0] lag;

    always_comb
    begin
        w_eff = (width_reg == '0) ? 11'd1 :
                (width_reg > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_reg;
        h_eff = (height_reg == '0) ? 13'd1 :
                (height_reg > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : height_reg;
        off   = (win_reg == '0) ? '0 : OFF_BITS'((win_reg - 3'd1) >> 1);
        if (32'(off) > MAX_OFF)
        begin
            off = OFF_BITS'(MAX_OFF);
        end
        side = {off, 1'b1};
        taps = TAP_BITS'(side) * TAP_BITS'(side);
        lag  = LEAD_BITS'(off) * LEAD_BITS'(w_eff) + LEAD_BITS'(off);
    end

    // Position state.
    logic [ROW_BITS-1:0]  in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [COL_BITS-1:0]  in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [LEAD_BITS-1:0] lead_reg, lead_next;
    logic                 full_reg, full_next;
    mfw_state_t           state_reg, state_next;
    logic [OFF_BITS:0]    dr_reg, dr_next, dc_reg, dc_next;
    logic [TAP_BITS-1:0]  ld_reg, ld_next;
    logic                 ldv_reg, ldv_next;
    logic [TAP_BITS-1:0]  ldi_reg;
    logic [15:0]          pix_reg, pix_next;
    logic                 last_reg, last_next;
    logic                 mval_reg, mval_next;

    // Row store, one write and one registered read per cycle.
    logic [PIXEL_BITS-1:0] store [STORE_ROWS*MAX_WIDTH];
    logic [PIXEL_BITS-1:0] rd_data;
    logic                  st_we;
    logic [ADDR_BITS-1:0]  wr_addr, rd_addr;
    logic [ROW_BITS-1:0]   rd_row;
    logic [COL_BITS-1:0]   rd_col;

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store[wr_addr] <= s_tdata[PIXEL_BITS-1:0];
        end
        rd_data <= store[rd_addr];
    end

    assign wr_addr = {in_row_reg[SROW_BITS-1:0], in_col_reg};
    assign rd_addr = {rd_row[SROW_BITS-1:0], rd_col};

    logic rk_start, rk_done;
    logic [PIXEL_BITS-1:0] rk_result;

    mfw_ranker u_ranker (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (ldv_reg),
        .load_idx (ldi_reg),
        .load_val (rd_data),
        .start    (rk_start),
        .count    (taps),
        .done     (rk_done),
        .result   (rk_result)
    );

    logic accept, emit, inside_win, out_take;
    assign s_tready = (state_reg == ST_IDLE) && !mval_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_take = m_tvalid && m_tready;
    assign inside_win = (out_row_reg >= ROW_BITS'(off))
        && ({1'b0, out_row_reg} + (ROW_BITS+1)'(off) < (ROW_BITS+1)'(h_eff))
        && (out_col_reg >= COL_BITS'(off))
        && ({1'b0, out_col_reg} + (COL_BITS+1)'(off) < (COL_BITS+1)'(w_eff));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !(s_tuser && !full_reg) && emit)
                begin
                    state_next = inside_win ? ST_LOAD : ST_PASS_RD;
                end
            end
            ST_PASS_RD: state_next = ST_OUT;
            ST_LOAD:
            begin
                if (ld_reg == taps)
                begin
                    state_next = ST_RANK;
                end
            end
            ST_RANK:
            begin
                if (rk_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        lead_next    = lead_reg;
        full_next    = full_reg;
        dr_next      = dr_reg;
        dc_next      = dc_reg;
        ld_next      = ld_reg;
        ldv_next     = 1'b0;
        pix_next     = pix_reg;
        last_next    = last_reg;
        mval_next    = mval_reg && !out_take;
        st_we        = 1'b0;
        rk_start     = 1'b0;
        emit         = 1'b0;
        rd_row       = out_row_reg;
        rd_col       = out_col_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !(s_tuser && !full_reg))
                begin
                    if (!full_reg)
                    begin
                        st_we = 1'b1;
                        if ({1'b0, in_col_reg} + 1'b1 >= (COL_BITS+1)'(w_eff))
                        begin
                            in_col_next = '0;
                            if ({1'b0, in_row_reg} + 1'b1 >= (ROW_BITS+1)'(h_eff))
                            begin
                                full_next = 1'b1;
                            end
                            else
                            begin
                                in_row_next = in_row_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            in_col_next = in_col_reg + 1'b1;
                        end
                    end
                    if (lead_reg + 1'b1 > lag)
                    begin
                        emit = 1'b1;
                        dr_next = '0;
                        dc_next = '0;
                        ld_next = '0;
                    end
                    else
                    begin
                        lead_next = lead_reg + 1'b1;
                    end
                end
            end
            ST_PASS_RD: ;
            ST_LOAD:
            begin
                // Walk the window, one store read per cycle.
                rd_row = out_row_reg - ROW_BITS'(off) + ROW_BITS'(dr_reg);
                rd_col = out_col_reg - COL_BITS'(off) + COL_BITS'(dc_reg);
                if (ld_reg == taps)
                begin
                    rk_start = 1'b1;
                end
                else
                begin
                    ldv_next = 1'b1;
                    ld_next  = ld_reg + 1'b1;
                    if (dc_reg == (OFF_BITS+1)'(side - 3'd1))
                    begin
                        dc_next = '0;
                        dr_next = dr_reg + 1'b1;
                    end
                    else
                    begin
                        dc_next = dc_reg + 1'b1;
                    end
                end
            end
            ST_RANK:
            begin
                if (rk_done)
                begin
                    pix_next = rk_result;
                end
            end
            ST_OUT:  pix_next = rd_data;
            default: ;
        endcase

        // Advance the output position once the pixel is ready.
        if ((state_reg == ST_OUT) || (state_reg == ST_RANK && rk_done))
        begin
            mval_next = 1'b1;
            last_next = 1'b0;
            if ({1'b0, out_col_reg} + 1'b1 >= (COL_BITS+1)'(w_eff))
            begin
                out_col_next = '0;
                if ({1'b0, out_row_reg} + 1'b1 >= (ROW_BITS+1)'(h_eff))
                begin
                    last_next = 1'b1;
                end
                else
                begin
                    out_row_next = out_row_reg + 1'b1;
                end
            end
            else
            begin
                out_col_next = out_col_reg + 1'b1;
            end
            if (last_next)
            begin
                in_row_next  = '0;
                in_col_next  = '0;
                out_row_next = '0;
                out_col_next = '0;
                lead_next    = '0;
                full_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            lead_reg    <= '0;
            full_reg    <= 1'b0;
            mval_reg    <= 1'b0;
            ldv_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            lead_reg    <= lead_next;
            full_reg    <= full_next;
            mval_reg    <= mval_next;
            ldv_reg     <= ldv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dr_reg   <= dr_next;
        dc_reg   <= dc_next;
        ld_reg   <= ld_next;
        ldi_reg  <= ld_reg;
        pix_reg  <= pix_next;
        last_reg <= last_next;
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = pix_reg;
    assign m_tlast  = last_reg;

    // A new transfer is never taken while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n) m_tvalid |-> !s_tready)
        else $error("input taken while result pending");
    // The ranker only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n) rk_done |-> state_reg == ST_RANK)
        else $error("ranker done outside rank phase");
    // The tap counter never runs past the window size.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD |-> ld_reg <= taps)
        else $error("tap count overrun");

endmodule

// ===== dv/mfw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfw_checker
// Watches the pixel streams and the register port of the median filter,
// predicts every output pixel and compares it with what the block sends.
// ----------------------------------------------------------------------------
module mfw_checker
    import mfw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] pixel_in
    input  logic        s_tuser,   // kind
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [15:0] pixel_out
    input  logic        m_tlast,   // frame_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [15:0] pixel;
        logic        frame_end;
    } out_pixel_t;

    out_pixel_t   expected_pixels[$];
    logic [15:0]  line_mem [STORE_ROWS*MAX_WIDTH];
    int unsigned  in_r, in_c, out_r, out_c, lead;
    bit           in_done;
    logic [2:0]   cfg_window;
    logic [10:0]  cfg_width;
    logic [12:0]  cfg_height;

    assign pending = expected_pixels.size();

    function automatic int unsigned line_addr(int unsigned r, int unsigned c);
        return (r % STORE_ROWS) * MAX_WIDTH + (c % MAX_WIDTH);
    endfunction

    // Gathers the square window around (r, c) and returns the middle rank.
    function automatic logic [15:0] window_median(int unsigned r, int unsigned c,
                                                  int unsigned off);
        logic [15:0] taps [MAX_TAPS];
        logic [15:0] x;
        int n;
        int j;
        n = 0;
        for (int unsigned rr = r - off; rr <= r + off; rr++)
            for (int unsigned cc = c - off; cc <= c + off; cc++)
            begin
                taps[n] = line_mem[line_addr(rr, cc)];
                n++;
            end
        for (int i = 1; i < n; i++)
        begin
            x = taps[i];
            j = i;
            while (j > 0 && taps[j-1] > x)
            begin
                taps[j] = taps[j-1];
                j--;
            end
            taps[j] = x;
        end
        return taps[n/2];
    endfunction

    // Advances the predicted filter by one accepted input transfer.
    task automatic predict_filter(logic kind, logic [15:0] pix);
        int unsigned w, h, off, lag;
        out_pixel_t res;
        bit wrap;
        w   = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
        h   = (cfg_height == 0) ? 1 : ((cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height);
        off = (cfg_window == 0) ? 0 : (cfg_window - 1) / 2;
        if (off > MAX_OFF)
            off = MAX_OFF;
        lag = off * w + off;
        if (!in_done)
        begin
            // A flush before the frame is complete is ignored.
            if (kind)
                return;
            line_mem[line_addr(in_r, in_c)] = pix;
            if (in_c + 1 >= w)
            begin
                in_c = 0;
                if (in_r + 1 >= h)
                    in_done = 1'b1;
                else
                    in_r++;
            end
            else
                in_c++;
        end
        lead++;
        if (lead <= lag)
            return;
        lead--;
        if (out_r >= off && out_r + off < h && out_c >= off && out_c + off < w)
            res.pixel = window_median(out_r, out_c, off);
        else
            res.pixel = line_mem[line_addr(out_r, out_c)];
        wrap = 1'b0;
        if (out_c + 1 >= w)
        begin
            out_c = 0;
            if (out_r + 1 >= h)
                wrap = 1'b1;
            else
                out_r++;
        end
        else
            out_c++;
        res.frame_end = wrap;
        if (wrap)
        begin
            in_r = 0; in_c = 0; out_r = 0; out_c = 0; lead = 0;
            in_done = 1'b0;
        end
        expected_pixels.push_back(res);
    endtask

    // Output compare runs before prediction so a transfer never meets its own result.
    always @(posedge clk or negedge rst_n)
    begin
        out_pixel_t exp_pix;
        if (!rst_n)
        begin
            expected_pixels.delete();
            in_r = 0; in_c = 0; out_r = 0; out_c = 0; lead = 0;
            in_done    = 1'b0;
            cfg_window = 3'd3;
            cfg_width  = 11'd1024;
            cfg_height = 13'd1024;
            fail_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected output pixel %h last %b",
                                 $realtime, m_tdata, m_tlast);
                end
                else
                begin
                    exp_pix = expected_pixels.pop_front();
                    if (exp_pix.pixel !== m_tdata || exp_pix.frame_end !== m_tlast)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: pixel mismatch exp %h/%b got %h/%b",
                                     $realtime, exp_pix.pixel, exp_pix.frame_end,
                                     m_tdata, m_tlast);
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_WINDOW: cfg_window = pwdata[2:0];
                    REG_WIDTH:  cfg_width  = pwdata[10:0];
                    REG_HEIGHT: cfg_height = pwdata[12:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_filter(s_tuser, s_tdata);
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Frame stimulus for the median filter window block.
// ----------------------------------------------------------------------------
// Writes a window size and frame geometry, streams one frame in raster order
// and its flush tail, and repeats over directed and random geometries with
// varying idle and stall patterns. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import mfw_pkg::*;

    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 3000;
    localparam int HOLD_CYCLES = 4000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;     // [15:0] pixel_in
    logic        s_tuser = 1'b0;   // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [15:0] pixel_out
    logic        m_tlast;          // frame_end
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int pixels_sent = 0;
    int idle_cycles = 0;
    bit hold_go = 1'b0;
    int hold_left = 0;

    median_filter_window dut (.*);

    mfw_checker checker_i (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver side: random stalls, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_go && hold_left == 0)
        begin
            hold_left <= HOLD_CYCLES;
            hold_go   <= 1'b0;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles with no transfer on either stream.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_item(logic kind, logic [15:0] pix);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= pix;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [15:0] some_pixel(bit corners);
        int pick;
        pick = $urandom_range(3);
        if (corners && pick == 0)
            return 16'h0000;
        if (corners && pick == 1)
            return 16'hFFFF;
        return 16'($urandom_range(16'hFFFF));
    endfunction

    // One frame: registers, raster pixels, then the flush tail.
    task automatic run_frame(int win, int wid, int hgt, bit corners);
        int w, h, off, lag;
        w   = (wid == 0) ? 1 : ((wid > MAX_WIDTH) ? MAX_WIDTH : wid);
        h   = (hgt == 0) ? 1 : ((hgt > MAX_HEIGHT) ? MAX_HEIGHT : hgt);
        off = (win == 0) ? 0 : (win - 1) / 2;
        lag = off * w + off;
        // The block may still be busy with ignored flushes; let it settle.
        while (pending != 0)
            @(posedge clk);
        s_tvalid <= 1'b0;
        repeat (DRAIN_WAIT) @(posedge clk);
        reg_write(REG_WINDOW, win);
        reg_write(REG_WIDTH, wid);
        reg_write(REG_HEIGHT, hgt);
        for (int i = 0; i < w * h; i++)
        begin
            // An early flush inside the frame must be ignored.
            if (i != 0 && $urandom_range(19) == 0)
                send_item(1'b1, some_pixel(1'b0));
            send_item(1'b0, some_pixel(corners));
            pixels_sent++;
        end
        // Tail: flushes, or extra pixels which act as flushes.
        for (int i = 0; i < lag; i++)
        begin
            send_item(1'($urandom_range(1)), some_pixel(1'b0));
            pixels_sent++;
        end
        repeat ($urandom_range(2))
            send_item(1'b1, some_pixel(1'b0));
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int phase;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed geometries, even and odd windows, edge cases.
        run_frame(3, 4, 4, 1'b1);
        run_frame(1, 1, 1, 1'b1);
        run_frame(0, 3, 2, 1'b1);
        run_frame(7, 7, 7, 1'b1);
        run_frame(6, 8, 8, 1'b1);
        run_frame(4, 6, 6, 1'b1);
        run_frame(2, 5, 5, 1'b1);
        run_frame(7, 1, 1, 1'b1);
        run_frame(5, 0, 0, 1'b1);
        run_frame(7, 2, 9, 1'b0);
        run_frame(1, 2047, 1, 1'b0);

        // Random frames, rotating the idle and stall patterns.
        phase = 0;
        while (pixels_sent < 1600 || phase < 5)
        begin
            case (phase % 5)
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                3: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (phase == 2)
                hold_go <= 1'b1;
            run_frame($urandom_range(7),
                      ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 12),
                      ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 12),
                      1'($urandom_range(1)));
            phase++;
        end

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== median_filter_window.f =====
rtl/core/mfw_pkg.sv
rtl/core/mfw_ranker.sv
rtl/core/median_filter_window.sv
dv/mfw_checker.sv
dv/tb_top.sv
